// ----- src/bliu_pkg.sv -----
// Package for the bilinear image upscaler: field widths, codes, defaults
// and the struct shared between the top level and the filter stages.
// No dependencies.
`default_nettype none
package bliu_pkg;

    localparam int IDX_W   = 17;
    localparam int COORD_W = 12;
    localparam int CFG_W   = 13;
    localparam int CH_W    = 8;
    localparam int RGB_W   = 3 * CH_W;
    localparam int PIX_W   = 32;
    localparam int PAW     = 3;
    localparam int PDW     = 32;

    localparam int SRC_WIDTH_DEF  = 320;
    localparam int SRC_HEIGHT_DEF = 240;

    localparam logic [CFG_W-1:0] OUT_WIDTH_RST  = 13'd320;
    localparam logic [CFG_W-1:0] OUT_HEIGHT_RST = 13'd240;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic REG_OUT_WIDTH  = 1'b0;
    localparam logic REG_OUT_HEIGHT = 1'b1;

    localparam logic [CH_W-1:0] ALPHA = 8'hFF;

    typedef struct packed {
        logic            valid;
        logic            xpar;
        logic            ypar;
        logic [CH_W-1:0] fx;
        logic [CH_W-1:0] fy;
    } smp_tag_t;

endpackage
`default_nettype wire

// ----- src/bliu_in_if.sv -----
// Input channel of the upscaler: valid/ready handshake plus one item.
// Depends on bliu_pkg.
`default_nettype none
interface bliu_in_if
    import bliu_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [IDX_W-1:0]   src_index;
    logic [CH_W-1:0]    load_red;
    logic [CH_W-1:0]    load_green;
    logic [CH_W-1:0]    load_blue;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;

    modport source (output valid, opcode, src_index, load_red, load_green, load_blue,
                    out_x, out_y, input ready);
    modport sink   (input valid, opcode, src_index, load_red, load_green, load_blue,
                    out_x, out_y, output ready);
endinterface
`default_nettype wire

// ----- src/bliu_out_if.sv -----
// Output channel of the upscaler: valid/ready handshake plus one pixel.
// Depends on bliu_pkg.
`default_nettype none
interface bliu_out_if
    import bliu_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, pixel, input ready);
    modport sink   (input valid, pixel, output ready);
endinterface
`default_nettype wire

// ----- src/bliu_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// No package dependency.
`default_nettype none
module bliu_div #(
    parameter int NUMW = 29,
    parameter int DW   = 13
) (
    input  wire logic            clk,
    input  wire logic            en,
    input  wire logic [NUMW-1:0] num,
    input  wire logic [DW-1:0]   den,
    output logic      [NUMW-1:0] quot
);

    logic [DW-1:0]   rem_reg [NUMW];
    logic [NUMW-1:0] num_reg [NUMW];
    logic [NUMW-1:0] q_reg   [NUMW];
    logic [DW-1:0]   d_reg   [NUMW];

    logic [DW-1:0]   rem_in  [NUMW];
    logic [NUMW-1:0] num_in  [NUMW];
    logic [NUMW-1:0] q_in    [NUMW];
    logic [DW-1:0]   d_in    [NUMW];
    logic [DW:0]     trial   [NUMW];
    logic            ge      [NUMW];
    logic [DW-1:0]   rem_next[NUMW];

    always_comb
    begin
        for (int k = 0; k < NUMW; k++)
        begin
            if (k == 0)
            begin
                rem_in[k] = '0;
                num_in[k] = num;
                q_in[k]   = '0;
                d_in[k]   = den;
            end
            else
            begin
                rem_in[k] = rem_reg[k-1];
                num_in[k] = num_reg[k-1];
                q_in[k]   = q_reg[k-1];
                d_in[k]   = d_reg[k-1];
            end
            trial[k] = {rem_in[k], num_in[k][NUMW-1]};
            ge[k]    = trial[k] >= {1'b0, d_in[k]};
            if (ge[k])
                rem_next[k] = DW'(trial[k] - {1'b0, d_in[k]});
            else
                rem_next[k] = trial[k][DW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NUMW; k++)
            begin
                rem_reg[k] <= rem_next[k];
                num_reg[k] <= num_in[k] << 1;
                q_reg[k]   <= {q_in[k][NUMW-2:0], ge[k]};
                d_reg[k]   <= d_in[k];
            end
        end
    end

    assign quot = q_reg[NUMW-1];

endmodule
`default_nettype wire

// ----- src/bliu_ldec.sv -----
// Load address decoder: raster index to bank and bank address, four stages.
// Depends on bliu_pkg.
`default_nettype none
module bliu_ldec
    import bliu_pkg::*;
#(
    parameter int SRC_WIDTH  = SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT = SRC_HEIGHT_DEF,
    parameter int AW         = 15
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [IDX_W-1:0] idx,
    output logic                  ok,
    output logic      [1:0]       bank,
    output logic      [AW-1:0]    addr
);

    localparam int DEPTH = SRC_WIDTH * SRC_HEIGHT;
    localparam int RECIP = (2 ** IDX_W) / SRC_WIDTH;
    localparam int HW    = (SRC_WIDTH + 1) / 2;
    localparam int XW    = $clog2(SRC_WIDTH);
    localparam int RW    = XW + 2;

    logic [IDX_W-1:0]   idx1_reg;
    logic [2*IDX_W-1:0] prod_reg;
    logic               ok1_reg, ok2_reg, ok3_reg, ok4_reg;
    logic [IDX_W-1:0]   y0_reg, y_reg;
    logic [RW-1:0]      r_reg;
    logic [XW-1:0]      x_reg;
    logic [1:0]         bank_reg;
    logic [AW-1:0]      addr_reg;

    logic [IDX_W-1:0]   y0;
    logic [IDX_W-1:0]   m;

    assign y0 = prod_reg[2*IDX_W-1:IDX_W];
    assign m  = IDX_W'(y0 * SRC_WIDTH);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx1_reg <= idx;
            prod_reg <= (2*IDX_W)'(idx * RECIP);
            ok1_reg  <= 32'(idx) < DEPTH;

            y0_reg   <= y0;
            r_reg    <= RW'(idx1_reg - m);
            ok2_reg  <= ok1_reg;

            if (32'(r_reg) >= SRC_WIDTH)
            begin
                y_reg <= y0_reg + 1'b1;
                x_reg <= XW'(32'(r_reg) - SRC_WIDTH);
            end
            else
            begin
                y_reg <= y0_reg;
                x_reg <= r_reg[XW-1:0];
            end
            ok3_reg  <= ok2_reg;

            bank_reg <= {y_reg[0], x_reg[0]};
            addr_reg <= AW'(32'(y_reg >> 1) * HW + 32'(x_reg >> 1));
            ok4_reg  <= ok3_reg;
        end
    end

    assign ok   = ok4_reg;
    assign bank = bank_reg;
    assign addr = addr_reg;

endmodule
`default_nettype wire

// ----- src/bliu_filt.sv -----
// Bilinear filter stages: horizontal blend on two rows, then vertical blend.
// Depends on bliu_pkg.
`default_nettype none
module bliu_filt
    import bliu_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire smp_tag_t              tag,
    input  wire logic [3:0][RGB_W-1:0] rd,
    output logic                       out_valid,
    output logic      [PIX_W-1:0]      pixel
);

    function automatic logic [CH_W-1:0] lerp8(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b,
                                              input logic [CH_W-1:0] f);
        logic signed [8:0]  diff;
        logic signed [17:0] prod;
        logic signed [17:0] sh;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        prod = diff * $signed({1'b0, f});
        sh   = prod >>> 8;
        return a + sh[CH_W-1:0];
    endfunction

    logic [RGB_W-1:0] a0, b0, a1, b1;
    logic [RGB_W-1:0] t0_reg, t1_reg;
    logic [CH_W-1:0]  fy_reg;
    logic             va_reg, vb_reg;
    logic [PIX_W-1:0] pix_reg;

    assign a0 = rd[{tag.ypar, tag.xpar}];
    assign b0 = rd[{tag.ypar, ~tag.xpar}];
    assign a1 = rd[{~tag.ypar, tag.xpar}];
    assign b1 = rd[{~tag.ypar, ~tag.xpar}];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= tag.valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                t0_reg[c*CH_W +: CH_W] <= lerp8(a0[c*CH_W +: CH_W], b0[c*CH_W +: CH_W], tag.fx);
                t1_reg[c*CH_W +: CH_W] <= lerp8(a1[c*CH_W +: CH_W], b1[c*CH_W +: CH_W], tag.fx);
            end
            fy_reg <= tag.fy;
            pix_reg[PIX_W-1 -: CH_W] <= ALPHA;
            for (int c = 0; c < 3; c++)
                pix_reg[c*CH_W +: CH_W] <= lerp8(t0_reg[c*CH_W +: CH_W],
                                                 t1_reg[c*CH_W +: CH_W], fy_reg);
        end
    end

    assign out_valid = vb_reg;
    assign pixel     = pix_reg;

endmodule
`default_nettype wire

// ----- src/bilinear_image_upscaler_top.sv -----
// Top level of the bilinear image upscaler: input stage, dividers, load decoder,
// four-bank source image, filter stages and APB register port.
// Depends on bliu_pkg, bliu_in_if, bliu_out_if, bliu_div, bliu_ldec, bliu_filt.
`default_nettype none
// Takes one item per clock while the output is not stalled and returns one
// pixel for each sample request (loads return nothing), in order. The source
// position dividers are NUMW = 12 + clog2(max(SRC_WIDTH, SRC_HEIGHT)) + 8 bits
// wide and resolve one quotient bit per stage. The image is held in four banks
// split by row and column parity, so the four neighbors of a sample are read in
// the same cycle. A load becomes visible to every request accepted after it.
// The pipeline stalls as a whole while a finished pixel is not taken.
// out_width and out_height are at byte addresses 0 and 4 and should be written
// only while the block is idle.
module bilinear_image_upscaler_top
    import bliu_pkg::*;
#(
    parameter int SRC_WIDTH  = SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT = SRC_HEIGHT_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    bliu_in_if.sink             in_chan,
    bliu_out_if.source          out_chan,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [PAW-1:0] paddr,
    input  wire logic [PDW-1:0] pwdata,
    output logic      [PDW-1:0] prdata,
    output logic                pready
);

    localparam int MW     = $clog2((SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT);
    localparam int NUMW   = COORD_W + MW + 8;
    localparam int IPW    = NUMW - 8;
    localparam int HW     = (SRC_WIDTH + 1) / 2;
    localparam int HH     = (SRC_HEIGHT + 1) / 2;
    localparam int BDEPTH = HW * HH;
    localparam int AW     = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
    localparam int LQN    = NUMW - 4;

    typedef struct packed {
        logic             op;
        logic [RGB_W-1:0] rgb;
    } tag_t;

    typedef struct packed {
        logic          ok;
        logic [1:0]    bank;
        logic [AW-1:0] addr;
    } ld_t;

    // registers
    logic [CFG_W-1:0] out_width_reg, out_height_reg;
    logic             en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_width_reg  <= OUT_WIDTH_RST;
            out_height_reg <= OUT_HEIGHT_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_OUT_WIDTH:  out_width_reg  <= pwdata[CFG_W-1:0];
                REG_OUT_HEIGHT: out_height_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_OUT_WIDTH:  prdata = PDW'(out_width_reg);
            REG_OUT_HEIGHT: prdata = PDW'(out_height_reg);
            default:        prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // input stage
    logic               s0_valid_reg;
    logic               s0_op_reg;
    logic [IDX_W-1:0]   s0_idx_reg;
    logic [RGB_W-1:0]   s0_rgb_reg;
    logic [COORD_W-1:0] s0_x_reg, s0_y_reg;

    assign en            = !out_chan.valid || out_chan.ready;
    assign in_chan.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (en)
            s0_valid_reg <= in_chan.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_op_reg  <= in_chan.opcode;
            s0_idx_reg <= in_chan.src_index;
            s0_rgb_reg <= {in_chan.load_red, in_chan.load_green, in_chan.load_blue};
            s0_x_reg   <= in_chan.out_x;
            s0_y_reg   <= in_chan.out_y;
        end
    end

    // dividers
    logic [IPW-1:0]   prod_x, prod_y;
    logic [NUMW-1:0]  num_x, num_y, qx, qy;
    logic [CFG_W-1:0] den_x, den_y;

    assign prod_x = IPW'(32'(s0_x_reg) * (SRC_WIDTH - 1));
    assign prod_y = IPW'(32'(s0_y_reg) * (SRC_HEIGHT - 1));
    assign num_x  = {prod_x, 8'h00};
    assign num_y  = {prod_y, 8'h00};
    assign den_x  = (out_width_reg > 13'd1) ? out_width_reg - 13'd1 : 13'd1;
    assign den_y  = (out_height_reg > 13'd1) ? out_height_reg - 13'd1 : 13'd1;

    bliu_div #(.NUMW(NUMW), .DW(CFG_W)) u_div_x (
        .clk(clk), .en(en), .num(num_x), .den(den_x), .quot(qx)
    );

    bliu_div #(.NUMW(NUMW), .DW(CFG_W)) u_div_y (
        .clk(clk), .en(en), .num(num_y), .den(den_y), .quot(qy)
    );

    // load decoder and delay lines
    ld_t  ld_out;
    logic tv_reg  [NUMW];
    tag_t tag_reg [NUMW];
    ld_t  lq_reg  [LQN];

    bliu_ldec #(.SRC_WIDTH(SRC_WIDTH), .SRC_HEIGHT(SRC_HEIGHT), .AW(AW)) u_ldec (
        .clk(clk), .en(en), .idx(s0_idx_reg),
        .ok(ld_out.ok), .bank(ld_out.bank), .addr(ld_out.addr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUMW; k++)
                tv_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            tv_reg[0] <= s0_valid_reg;
            for (int k = 1; k < NUMW; k++)
                tv_reg[k] <= tv_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0].op  <= s0_op_reg;
            tag_reg[0].rgb <= s0_rgb_reg;
            for (int k = 1; k < NUMW; k++)
            begin
                tag_reg[k].op  <= tag_reg[k-1].op;
                tag_reg[k].rgb <= tag_reg[k-1].rgb;
            end
            lq_reg[0] <= ld_out;
            for (int k = 1; k < LQN; k++)
                lq_reg[k] <= lq_reg[k-1];
        end
    end

    // address stage
    tag_t           dtag;
    logic           dvalid;
    ld_t            dld;
    logic [IPW-1:0] ipx, ipy;
    logic [MW-1:0]  xi, yi;
    logic [CH_W-1:0] fx, fy;
    logic [MW:0]    xx [4];
    logic [MW:0]    yy [4];
    logic [AW-1:0]  req_addr [4];

    assign dtag   = tag_reg[NUMW-1];
    assign dvalid = tv_reg[NUMW-1];
    assign dld    = lq_reg[LQN-1];
    assign ipx    = qx[NUMW-1:8];
    assign ipy    = qy[NUMW-1:8];

    always_comb
    begin
        if (ipx > IPW'(SRC_WIDTH - 2))
        begin
            xi = MW'(SRC_WIDTH - 2);
            fx = '0;
        end
        else
        begin
            xi = ipx[MW-1:0];
            fx = qx[7:0];
        end
        if (ipy > IPW'(SRC_HEIGHT - 2))
        begin
            yi = MW'(SRC_HEIGHT - 2);
            fy = '0;
        end
        else
        begin
            yi = ipy[MW-1:0];
            fy = qy[7:0];
        end
        for (int b = 0; b < 4; b++)
        begin
            xx[b] = {1'b0, xi} + (MW+1)'(xi[0] != b[0]);
            yy[b] = {1'b0, yi} + (MW+1)'(yi[0] != b[1]);
            req_addr[b] = AW'(32'(yy[b] >> 1) * HW + 32'(xx[b] >> 1));
        end
    end

    logic             p1_valid_reg;
    logic             p1_op_reg;
    logic             p1_ok_reg;
    logic [1:0]       p1_wbank_reg;
    logic [RGB_W-1:0] p1_wdata_reg;
    logic [AW-1:0]    p1_addr_reg [4];
    smp_tag_t         p1_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (en)
            p1_valid_reg <= dvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_op_reg    <= dtag.op;
            p1_ok_reg    <= dld.ok;
            p1_wbank_reg <= dld.bank;
            p1_wdata_reg <= dtag.rgb;
            for (int b = 0; b < 4; b++)
                p1_addr_reg[b] <= (dtag.op == OP_LOAD) ? dld.addr : req_addr[b];
            p1_tag_reg.valid <= 1'b0;
            p1_tag_reg.xpar  <= xi[0];
            p1_tag_reg.ypar  <= yi[0];
            p1_tag_reg.fx    <= fx;
            p1_tag_reg.fy    <= fy;
        end
    end

    // image banks
    logic [3:0][RGB_W-1:0] rd_all;
    smp_tag_t              p2_tag_reg;
    logic                  p2_valid_reg;
    smp_tag_t              p2_tag;

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [RGB_W-1:0] bank_mem [BDEPTH];
        logic [RGB_W-1:0] rd_reg;

        always_ff @(posedge clk)
        begin
            if (en && p1_valid_reg)
            begin
                if (p1_op_reg == OP_LOAD)
                begin
                    if (p1_ok_reg && p1_wbank_reg == 2'(b))
                        bank_mem[p1_addr_reg[b]] <= p1_wdata_reg;
                end
                else
                    rd_reg <= bank_mem[p1_addr_reg[b]];
            end
        end

        assign rd_all[b] = rd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else if (en)
            p2_valid_reg <= p1_valid_reg && (p1_op_reg == OP_SAMPLE);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            p2_tag_reg <= p1_tag_reg;
    end

    always_comb
    begin
        p2_tag       = p2_tag_reg;
        p2_tag.valid = p2_valid_reg;
    end

    bliu_filt u_filt (
        .clk(clk), .rst_n(rst_n), .en(en), .tag(p2_tag), .rd(rd_all),
        .out_valid(out_chan.valid), .pixel(out_chan.pixel)
    );

endmodule
`default_nettype wire
